[sv/ptrc_pkg.sv]
// ----------------------------------------------------------------------------
// ptrc_pkg - pressure threshold relay controller package
// Shared types and constants for the controller.
// ----------------------------------------------------------------------------
package ptrc_pkg;

   localparam int HOLD_W   = 16;
   localparam int QUAL_W   = 8;
   localparam int SAMPLE_W = 10;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [HOLD_W-1:0]   ENTER_HOLD_RESET   = 16'd1000;
   localparam logic [HOLD_W-1:0]   CAPTURE_HOLD_RESET = 16'd500;
   localparam logic [QUAL_W-1:0]   QUALIFY_RESET      = 8'd10;
   localparam logic [SAMPLE_W-1:0] THRESH_RESET       = 10'd1023;
   localparam logic [HOLD_W-1:0]   HOLD_MAX           = 16'hFFFF;

   typedef enum logic [1:0] {
      REG_ENTER_HOLD   = 2'd0,
      REG_CAPTURE_HOLD = 2'd1,
      REG_QUALIFY      = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [HOLD_W-1:0] enter_hold_ticks;
      logic [HOLD_W-1:0] capture_hold_ticks;
      logic [QUAL_W-1:0] qualify_count;
   } cfg_type;

   typedef struct packed {
      logic                relay_on;
      logic                programming_mode;
      logic [SAMPLE_W-1:0] threshold_now;
   } result_type;

endpackage

[sv/ptrc_csr.sv]
// ----------------------------------------------------------------------------
// ptrc_csr - configuration registers
// APB-style register file holding the hold limits and qualify count.
// ----------------------------------------------------------------------------
module ptrc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ptrc_pkg::CSR_AW-1:0]  paddr,
   input  logic [ptrc_pkg::CSR_DW-1:0]  pwdata,
   output logic [ptrc_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output ptrc_pkg::cfg_type            cfg
);

   ptrc_pkg::cfg_type       cfg_ff;
   ptrc_pkg::cfg_type       cfg_in;
   ptrc_pkg::reg_index_type index;
   logic                    wr_en;

   assign index  = ptrc_pkg::reg_index_type'(paddr[3:2]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            ptrc_pkg::REG_ENTER_HOLD: begin
               cfg_in.enter_hold_ticks = pwdata[ptrc_pkg::HOLD_W-1:0];
            end
            ptrc_pkg::REG_CAPTURE_HOLD: begin
               cfg_in.capture_hold_ticks = pwdata[ptrc_pkg::HOLD_W-1:0];
            end
            ptrc_pkg::REG_QUALIFY: begin
               cfg_in.qualify_count = pwdata[ptrc_pkg::QUAL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         ptrc_pkg::REG_ENTER_HOLD: begin
            prdata = {16'd0, cfg_ff.enter_hold_ticks};
         end
         ptrc_pkg::REG_CAPTURE_HOLD: begin
            prdata = {16'd0, cfg_ff.capture_hold_ticks};
         end
         ptrc_pkg::REG_QUALIFY: begin
            prdata = {24'd0, cfg_ff.qualify_count};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_hold_ticks   <= ptrc_pkg::ENTER_HOLD_RESET;
         cfg_ff.capture_hold_ticks <= ptrc_pkg::CAPTURE_HOLD_RESET;
         cfg_ff.qualify_count      <= ptrc_pkg::QUALIFY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/ptrc_core.sv]
// ----------------------------------------------------------------------------
// ptrc_core - hold timing, threshold capture and relay sensing
// Holds controller state; computes the next state and the result of one
// request in a single pass.
// ----------------------------------------------------------------------------
module ptrc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic                           button_pressed,
   input  logic [ptrc_pkg::SAMPLE_W-1:0]  pressure_sample,
   input  ptrc_pkg::cfg_type              cfg,
   output ptrc_pkg::result_type           result
);

   logic                          program_ff, program_in;
   logic [ptrc_pkg::HOLD_W-1:0]   hold_ff, hold_in;
   logic                          began_prog_ff, began_prog_in;
   logic [ptrc_pkg::SAMPLE_W-1:0] thresh_ff, thresh_in;
   logic                          above_ff, above_in;
   logic [ptrc_pkg::QUAL_W-1:0]   above_cnt_ff, above_cnt_in;
   logic                          relay_ff, relay_in;

   logic hold_zero;
   logic began;
   logic mode_prog;

   assign hold_zero = (hold_ff == '0);
   assign began     = hold_zero ? program_ff : began_prog_ff;
   assign mode_prog = hold_zero ? program_ff : began_prog_ff;

   always_comb begin
      program_in    = program_ff;
      hold_in       = hold_ff;
      began_prog_in = began_prog_ff;
      thresh_in     = thresh_ff;
      above_in      = above_ff;
      above_cnt_in  = above_cnt_ff;
      relay_in      = relay_ff;
      if (button_pressed) begin
         began_prog_in = began;
         if (began) begin
            if (hold_ff >= cfg.capture_hold_ticks) begin
               thresh_in  = pressure_sample;
               program_in = 1'b0;
            end
         end else if (hold_ff >= cfg.enter_hold_ticks) begin
            program_in = 1'b1;
         end
         if (hold_ff != ptrc_pkg::HOLD_MAX) begin
            hold_in = hold_ff + 16'd1;
         end
      end else begin
         hold_in       = '0;
         began_prog_in = 1'b0;
         if (!mode_prog) begin
            if (pressure_sample >= thresh_ff) begin
               if (above_ff) begin
                  if (above_cnt_ff < cfg.qualify_count) begin
                     above_cnt_in = above_cnt_ff + 8'd1;
                  end else begin
                     relay_in = 1'b1;
                  end
               end else begin
                  above_in     = 1'b1;
                  above_cnt_in = '0;
               end
            end else if (above_ff) begin
               above_in = 1'b0;
               relay_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_ff    <= 1'b0;
         hold_ff       <= '0;
         began_prog_ff <= 1'b0;
         thresh_ff     <= ptrc_pkg::THRESH_RESET;
         above_ff      <= 1'b0;
         above_cnt_ff  <= '0;
         relay_ff      <= 1'b0;
      end else if (step_en) begin
         program_ff    <= program_in;
         hold_ff       <= hold_in;
         began_prog_ff <= began_prog_in;
         thresh_ff     <= thresh_in;
         above_ff      <= above_in;
         above_cnt_ff  <= above_cnt_in;
         relay_ff      <= relay_in;
      end
   end

   assign result.relay_on         = relay_in;
   assign result.programming_mode = program_in;
   assign result.threshold_now    = thresh_in;

endmodule

[sv/pressure_threshold_relay_controller_unit.sv]
// ----------------------------------------------------------------------------
// pressure_threshold_relay_controller_unit - top level
// Button hold timing, threshold programming and relay control.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     button_pressed, pressure_sample
//   rsp      out        rsp_valid / rsp_ready     relay_on, programming_mode,
//                                                 threshold_now
//   csr      in/out     psel / penable / pready   paddr, pwdata, prdata
//
// One request per cycle while no stalled result holds it off; the cycle
// after acceptance, its result sits in the single result register behind the
// state update logic. Synchronous reset restores all but the result register.
// A stalled result holds in the result register; a new request is taken
// in the same cycle that the held result is taken.
// ----------------------------------------------------------------------------
module pressure_threshold_relay_controller_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_button_pressed,
   input  logic [ptrc_pkg::SAMPLE_W-1:0]  req_pressure_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_relay_on,
   output logic                           rsp_programming_mode,
   output logic [ptrc_pkg::SAMPLE_W-1:0]  rsp_threshold_now,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ptrc_pkg::CSR_AW-1:0]    paddr,
   input  logic [ptrc_pkg::CSR_DW-1:0]    pwdata,
   output logic [ptrc_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);

   ptrc_pkg::cfg_type    cfg;
   ptrc_pkg::result_type step_result;
   ptrc_pkg::result_type result_ff;
   logic                 valid_ff, valid_in;
   logic                 accept;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   ptrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ptrc_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step_en         (accept),
      .button_pressed  (req_button_pressed),
      .pressure_sample (req_pressure_sample),
      .cfg             (cfg),
      .result          (step_result)
   );

   assign valid_in = accept || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_relay_on         = result_ff.relay_on;
   assign rsp_programming_mode = result_ff.programming_mode;
   assign rsp_threshold_now    = result_ff.threshold_now;

endmodule
